@@ sv/mrlp_pkg.sv @@
`default_nettype none
package mrlp_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_DECIDE,
    S_CPY_RD,
    S_CPY_WR,
    S_CMP_RD,
    S_CMP_EV,
    S_OUT
  } state_t;

  localparam logic [1:0] OP_RX     = 2'd0;
  localparam logic [1:0] OP_BODY   = 2'd1;
  localparam logic [1:0] OP_SENDER = 2'd2;
  localparam logic [1:0] OP_REL    = 2'd3;

  localparam logic [1:0] REG_AUTH_LOW  = 2'd0;
  localparam logic [1:0] REG_AUTH_MID  = 2'd1;
  localparam logic [1:0] REG_AUTH_HIGH = 2'd2;
  localparam logic [1:0] REG_AUTH_LEN  = 2'd3;

  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_PROMPT = 8'h3e;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam int NUM_PAT  = 5;
  localparam int PAT_CMGS = 0;
  localparam int PAT_OK   = 1;
  localparam int PAT_ERR  = 2;
  localparam int PAT_RING = 3;
  localparam int PAT_CMT  = 4;

  localparam logic [4:0] AUTH_MAX = 5'd19;

  // patterns left aligned in six bytes
  localparam logic [47:0] STR_CMGS = "+CMGS:";
  localparam logic [47:0] STR_OK   = {"OK", 32'h0};
  localparam logic [47:0] STR_ERR  = {"ERROR", 8'h0};
  localparam logic [47:0] STR_RING = {"RING", 16'h0};
  localparam logic [47:0] STR_CMT  = {"+CMT:", 8'h0};

  function automatic logic [2:0] pat_len(input int p);
    case (p)
      PAT_CMGS: pat_len = 3'd6;
      PAT_OK:   pat_len = 3'd2;
      PAT_ERR:  pat_len = 3'd5;
      PAT_RING: pat_len = 3'd4;
      default:  pat_len = 3'd5;
    endcase
  endfunction

  function automatic logic [7:0] pat_char(input int p, input logic [2:0] k);
    logic [47:0] s;
    case (p)
      PAT_CMGS: s = STR_CMGS;
      PAT_OK:   s = STR_OK;
      PAT_ERR:  s = STR_ERR;
      PAT_RING: s = STR_RING;
      default:  s = STR_CMT;
    endcase
    pat_char = 8'(s >> (6'd40 - {k, 3'b000}));
  endfunction

  function automatic logic [7:0] auth_char(input logic [63:0] lo, input logic [63:0] mid,
                                           input logic [23:0] hi, input logic [4:0] i);
    logic [151:0] all;
    all = {hi, mid, lo};
    if (i < AUTH_MAX) auth_char = 8'(all >> {i, 3'b000});
    else auth_char = CH_NUL;
  endfunction

endpackage
`default_nettype wire

@@ sv/modem_response_line_parser.sv @@
`default_nettype none
// Modem response line parser. Each request (op, rx_byte, read_index) yields one result.
// Plain bytes, reads and release go from idle straight to the output state. A line feed that ends a
// non-empty line runs a sequencer over the single-port line memory: a scan that stops at a NUL or
// the line end, then a copy into the body or sender memory, then for a body a sender compare
// against the auth registers, up to the first mismatch or NUL. The input is not ready while the
// sequencer runs.
module modem_response_line_parser #(
  parameter int LINE_DEPTH   = 256,
  parameter int BODY_DEPTH   = 200,
  parameter int SENDER_DEPTH = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  read_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             line_complete,
  output logic             prompt_seen,
  output logic             send_confirmed,
  output logic             message_accepted,
  output logic             hang_up_request,
  output logic             message_available,
  output logic [7:0]       read_data
);

  localparam int LW   = $clog2(LINE_DEPTH);
  localparam int BW   = $clog2(BODY_DEPTH);
  localparam int SW   = $clog2(SENDER_DEPTH);
  localparam int CMPW = 12;

  mrlp_pkg::state_t state, state_next;

  logic [63:0] auth_lo, auth_mid;
  logic [23:0] auth_hi;
  logic [4:0]  auth_len;

  logic [7:0] line_mem [LINE_DEPTH];
  logic [7:0] body_mem [BODY_DEPTH];
  logic [7:0] sender_mem [SENDER_DEPTH];
  logic [7:0] line_q, body_q, sender_q;

  logic [LW-1:0] line_length, idx, tlen, q1, q2, cpy_n;
  logic          q1f, q2f, cpy_snd;
  logic [mrlp_pkg::NUM_PAT-1:0] mflags, mflags_next;
  logic [BW-1:0] body_len;
  logic [SW-1:0] sender_len;
  logic [4:0]    cmp_i;
  logic          aw_body, aw_conf, body_pending;
  logic [1:0]    op_r;
  logic          rd_ok;
  logic          r_lc, r_pr, r_sc, r_hu, r_ma;

  logic          accept, out_load;
  logic          line_we;
  logic [LW-1:0] line_wa, laddr;
  logic          is_cmgs, is_ok, is_err, is_ring, is_cmt, aw_b, sc, hu;
  logic [LW-1:0] diff, snd_n, body_n;
  logic [4:0]    alen_sat;
  logic [7:0]    cmp_a, cmp_s;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      auth_lo  <= '0;
      auth_mid <= '0;
      auth_hi  <= '0;
      auth_len <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mrlp_pkg::REG_AUTH_LOW:  auth_lo  <= cfg_data;
        mrlp_pkg::REG_AUTH_MID:  auth_mid <= cfg_data;
        mrlp_pkg::REG_AUTH_HIGH: auth_hi  <= cfg_data[23:0];
        mrlp_pkg::REG_AUTH_LEN:  auth_len <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // line byte write on request accept
  always_comb begin
    line_we = 1'b0;
    line_wa = line_length;
    if (accept && op == mrlp_pkg::OP_RX && rx_byte != mrlp_pkg::CH_CR &&
        rx_byte != mrlp_pkg::CH_LF) begin
      if (rx_byte == mrlp_pkg::CH_PROMPT && line_length == '0) begin
        line_we = 1'b1;
        line_wa = '0;
      end else if (line_length != LW'(LINE_DEPTH - 1)) begin
        line_we = 1'b1;
      end
    end
  end

  assign laddr = (state == mrlp_pkg::S_CPY_RD && cpy_snd) ? q1 + LW'(1) + idx : idx;

  always_ff @(posedge clk) begin
    if (line_we) line_mem[line_wa] <= rx_byte;
    if (state == mrlp_pkg::S_SCAN_RD || state == mrlp_pkg::S_CPY_RD) line_q <= line_mem[laddr];
  end

  always_ff @(posedge clk) begin
    if (state == mrlp_pkg::S_CPY_WR && !cpy_snd) body_mem[BW'(idx)] <= line_q;
    if (accept && op == mrlp_pkg::OP_BODY) body_q <= body_mem[BW'(read_index)];
  end

  always_ff @(posedge clk) begin
    if (state == mrlp_pkg::S_CPY_WR && cpy_snd) sender_mem[SW'(idx)] <= line_q;
    if (accept && op == mrlp_pkg::OP_SENDER) sender_q <= sender_mem[SW'(read_index)];
    else if (state == mrlp_pkg::S_CMP_RD) sender_q <= sender_mem[cmp_i[SW-1:0]];
  end

  always_comb begin
    mflags_next = mflags;
    for (int p = 0; p < mrlp_pkg::NUM_PAT; p++) begin
      if (idx < LW'(mrlp_pkg::pat_len(p)) && line_q != mrlp_pkg::pat_char(p, idx[2:0]))
        mflags_next[p] = 1'b0;
    end
  end

  always_comb begin
    is_cmgs = mflags[mrlp_pkg::PAT_CMGS] && tlen >= LW'(6);
    is_ok   = mflags[mrlp_pkg::PAT_OK]   && tlen == LW'(2);
    is_err  = mflags[mrlp_pkg::PAT_ERR]  && tlen == LW'(5);
    is_ring = mflags[mrlp_pkg::PAT_RING] && tlen == LW'(4);
    is_cmt  = mflags[mrlp_pkg::PAT_CMT]  && tlen >= LW'(5);
    sc      = !is_cmgs && aw_conf && is_ok;
    aw_b    = aw_body && !is_err;
    hu      = is_ring && !aw_b;
    diff    = q2 - q1 - LW'(1);
    snd_n   = (CMPW'(diff) > CMPW'(SENDER_DEPTH - 1)) ? LW'(SENDER_DEPTH - 1) : diff;
    body_n  = (CMPW'(tlen) > CMPW'(BODY_DEPTH - 1)) ? LW'(BODY_DEPTH - 1) : tlen;
    alen_sat = (auth_len > mrlp_pkg::AUTH_MAX) ? mrlp_pkg::AUTH_MAX : auth_len;
    cmp_a   = (cmp_i < alen_sat) ? mrlp_pkg::auth_char(auth_lo, auth_mid, auth_hi, cmp_i)
                                 : mrlp_pkg::CH_NUL;
    cmp_s   = (6'(cmp_i) < 6'(sender_len)) ? sender_q : mrlp_pkg::CH_NUL;
  end

  always_comb begin
    state_next = state;
    case (state)
      mrlp_pkg::S_IDLE: begin
        if (in_valid) begin
          if (op == mrlp_pkg::OP_RX && rx_byte == mrlp_pkg::CH_LF && line_length != '0)
            state_next = mrlp_pkg::S_SCAN_RD;
          else
            state_next = mrlp_pkg::S_OUT;
        end
      end
      mrlp_pkg::S_SCAN_RD:
        state_next = (idx == line_length) ? mrlp_pkg::S_DECIDE : mrlp_pkg::S_SCAN_EV;
      mrlp_pkg::S_SCAN_EV:
        state_next = (line_q == mrlp_pkg::CH_NUL) ? mrlp_pkg::S_DECIDE : mrlp_pkg::S_SCAN_RD;
      mrlp_pkg::S_DECIDE: begin
        if (is_cmt) state_next = (q1f && q2f) ? mrlp_pkg::S_CPY_RD : mrlp_pkg::S_OUT;
        else if (aw_b) state_next = mrlp_pkg::S_CPY_RD;
        else state_next = mrlp_pkg::S_OUT;
      end
      mrlp_pkg::S_CPY_RD: begin
        if (idx == cpy_n) state_next = cpy_snd ? mrlp_pkg::S_OUT : mrlp_pkg::S_CMP_RD;
        else state_next = mrlp_pkg::S_CPY_WR;
      end
      mrlp_pkg::S_CPY_WR: state_next = mrlp_pkg::S_CPY_RD;
      mrlp_pkg::S_CMP_RD: state_next = mrlp_pkg::S_CMP_EV;
      mrlp_pkg::S_CMP_EV:
        state_next = (cmp_a != cmp_s || cmp_a == mrlp_pkg::CH_NUL) ? mrlp_pkg::S_OUT
                                                                   : mrlp_pkg::S_CMP_RD;
      mrlp_pkg::S_OUT: if (!out_valid || out_ready) state_next = mrlp_pkg::S_IDLE;
      default: state_next = mrlp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == mrlp_pkg::S_IDLE);
    out_load = (state == mrlp_pkg::S_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mrlp_pkg::S_IDLE;
      line_length  <= '0;
      aw_body      <= 1'b0;
      aw_conf      <= 1'b0;
      body_pending <= 1'b0;
      body_len     <= '0;
      sender_len   <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      case (state)
        mrlp_pkg::S_IDLE: begin
          if (in_valid) begin
            op_r <= op;
            r_lc <= 1'b0;
            r_pr <= 1'b0;
            r_sc <= 1'b0;
            r_hu <= 1'b0;
            r_ma <= 1'b0;
            rd_ok <= 1'b0;
            case (op)
              mrlp_pkg::OP_RX: begin
                if (rx_byte == mrlp_pkg::CH_CR) begin
                end else if (rx_byte == mrlp_pkg::CH_PROMPT && line_length == '0) begin
                  line_length <= LW'(1);
                  r_lc <= 1'b1;
                  r_pr <= 1'b1;
                end else if (rx_byte != mrlp_pkg::CH_LF) begin
                  if (line_length != LW'(LINE_DEPTH - 1)) line_length <= line_length + LW'(1);
                  else line_length <= '0;
                end else if (line_length != '0) begin
                  r_lc   <= 1'b1;
                  idx    <= '0;
                  mflags <= '1;
                  q1f    <= 1'b0;
                  q2f    <= 1'b0;
                end
              end
              mrlp_pkg::OP_BODY:   rd_ok <= CMPW'(read_index) < CMPW'(body_len);
              mrlp_pkg::OP_SENDER: rd_ok <= CMPW'(read_index) < CMPW'(sender_len);
              default: body_pending <= 1'b0;
            endcase
          end
        end
        mrlp_pkg::S_SCAN_RD: if (idx == line_length) tlen <= idx;
        mrlp_pkg::S_SCAN_EV: begin
          if (line_q == mrlp_pkg::CH_NUL) begin
            tlen <= idx;
          end else begin
            mflags <= mflags_next;
            if (line_q == mrlp_pkg::CH_QUOTE) begin
              if (!q1f) begin
                q1  <= idx;
                q1f <= 1'b1;
              end else if (!q2f) begin
                q2  <= idx;
                q2f <= 1'b1;
              end
            end
            idx <= idx + LW'(1);
          end
        end
        mrlp_pkg::S_DECIDE: begin
          if (is_cmgs) aw_conf <= 1'b1;
          else if (sc || is_err) aw_conf <= 1'b0;
          aw_body     <= is_cmt;
          r_sc        <= sc;
          r_hu        <= hu;
          line_length <= '0;
          idx         <= '0;
          cmp_i       <= '0;
          cpy_snd     <= is_cmt;
          cpy_n       <= is_cmt ? snd_n : body_n;
        end
        mrlp_pkg::S_CPY_RD: begin
          if (idx == cpy_n) begin
            if (cpy_snd) sender_len <= SW'(cpy_n);
            else body_len <= BW'(cpy_n);
          end
        end
        mrlp_pkg::S_CPY_WR: idx <= idx + LW'(1);
        mrlp_pkg::S_CMP_EV: begin
          if (cmp_a == cmp_s && cmp_a == mrlp_pkg::CH_NUL) begin
            r_ma         <= 1'b1;
            body_pending <= 1'b1;
          end else if (cmp_a == cmp_s) begin
            cmp_i <= cmp_i + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      line_complete     <= r_lc;
      prompt_seen       <= r_pr;
      send_confirmed    <= r_sc;
      message_accepted  <= r_ma;
      hang_up_request   <= r_hu;
      message_available <= body_pending;
      if (!rd_ok) read_data <= mrlp_pkg::CH_NUL;
      else if (op_r == mrlp_pkg::OP_BODY) read_data <= body_q;
      else read_data <= sender_q;
    end
  end

  a_accept_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_accepted |-> message_available)
    else $error("accepted message not flagged available");

  a_prompt_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && prompt_seen |-> line_complete && !send_confirmed && !hang_up_request)
    else $error("prompt result malformed");

  a_cmp_bound: assert property (@(posedge clk) disable iff (rst)
    state == mrlp_pkg::S_CMP_EV |-> cmp_i <= mrlp_pkg::AUTH_MAX)
    else $error("sender compare ran past its end");

endmodule
`default_nettype wire

@@ dv/modem_response_line_parser_tb.sv @@
`default_nettype none
module modem_response_line_parser_tb;

  typedef struct {
    logic [1:0] op;
    logic [7:0] rx;
    logic [7:0] idx;
  } req_t;

  typedef struct {
    logic       lc;
    logic       pr;
    logic       sc;
    logic       ma;
    logic       hu;
    logic       av;
    logic [7:0] rd;
  } resp_t;

  typedef logic [7:0] byte_q_t[$];

  localparam int LINE_D   = 256;
  localparam int BODY_D   = 200;
  localparam int SENDER_D = 20;
  localparam int DRAIN    = 1200;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic [1:0]  cfg_index = mrlp_pkg::REG_AUTH_LOW;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 0;
  logic [1:0]  op = mrlp_pkg::OP_RX;
  logic [7:0]  rx_byte = '0;
  logic [7:0]  read_index = '0;
  logic        out_ready = 0;
  wire         cfg_ready, in_ready, out_valid;
  wire         line_complete, prompt_seen, send_confirmed, message_accepted;
  wire         hang_up_request, message_available;
  wire [7:0]   read_data;

  modem_response_line_parser dut (.*);

  always #6 clk = ~clk;

  // parser shadow state
  logic [63:0] auth_lo = '0, auth_mid = '0;
  logic [23:0] auth_hi = '0;
  logic [4:0]  auth_len = '0;
  logic [7:0]  line_mem[LINE_D];
  int          line_len = 0;
  logic        wait_body = 0, wait_conf = 0, pending = 0;
  logic [7:0]  body_mem[BODY_D] = '{default: '0};
  logic [7:0]  sender_mem[SENDER_D] = '{default: '0};

  req_t  request_q[$];
  resp_t expected_q[$];
  int    errors = 0;
  logic  req_taken = 0;
  int    burst_left = 0, gap_left = 0;
  req_t  drv_req;
  int    stall_cnt = 0;
  logic  stall_on = 0;

  task automatic report(string what, int exp_v, int got_v);
    $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $time);
    errors++;
  endtask

  function automatic logic [7:0] allowed_char(int i);
    logic [151:0] all;
    all = {auth_hi, auth_mid, auth_lo};
    if (i >= 19) return 8'h00;
    return all[i*8 +: 8];
  endfunction

  function automatic int allowed_count();
    int n, k;
    n = (auth_len > 19) ? 19 : int'(auth_len);
    for (k = 0; k < n; k++)
      if (allowed_char(k) == mrlp_pkg::CH_NUL) break;
    return k;
  endfunction

  function automatic int text_len();
    int i;
    for (i = 0; i < line_len; i++)
      if (line_mem[i] == mrlp_pkg::CH_NUL) break;
    return i;
  endfunction

  function automatic bit has_prefix(int len, string p);
    if (len < p.len()) return 0;
    for (int i = 0; i < p.len(); i++)
      if (line_mem[i] != p[i]) return 0;
    return 1;
  endfunction

  function automatic bit sender_ok();
    int slen, alen;
    alen = allowed_count();
    slen = 0;
    while (slen < SENDER_D && sender_mem[slen] != mrlp_pkg::CH_NUL) slen++;
    if (slen != alen) return 0;
    for (int i = 0; i < alen; i++)
      if (sender_mem[i] != allowed_char(i)) return 0;
    return 1;
  endfunction

  task automatic finish_line(output logic sc, output logic hu, output logic ma);
    int len, q1, q2, n;
    len = text_len();
    sc = 0;
    hu = 0;
    ma = 0;
    if (has_prefix(len, "+CMGS:")) wait_conf = 1;
    else if (wait_conf && len == 2 && has_prefix(len, "OK")) begin
      sc = 1;
      wait_conf = 0;
    end
    if (len == 5 && has_prefix(len, "ERROR")) begin
      wait_body = 0;
      wait_conf = 0;
    end
    if (len == 4 && has_prefix(len, "RING") && !wait_body) hu = 1;
    if (has_prefix(len, "+CMT:")) begin
      q1 = len;
      q2 = len;
      for (int i = 0; i < len; i++)
        if (line_mem[i] == mrlp_pkg::CH_QUOTE) begin
          q1 = i;
          break;
        end
      for (int i = q1 + 1; i < len; i++)
        if (line_mem[i] == mrlp_pkg::CH_QUOTE) begin
          q2 = i;
          break;
        end
      if (q1 < len && q2 < len) begin
        n = q2 - q1 - 1;
        if (n > SENDER_D - 1) n = SENDER_D - 1;
        for (int i = 0; i < SENDER_D; i++)
          sender_mem[i] = (i < n) ? line_mem[q1 + 1 + i] : mrlp_pkg::CH_NUL;
      end
      wait_body = 1;
    end else if (wait_body) begin
      n = (len > BODY_D - 1) ? BODY_D - 1 : len;
      for (int i = 0; i < BODY_D; i++)
        body_mem[i] = (i < n) ? line_mem[i] : mrlp_pkg::CH_NUL;
      wait_body = 0;
      if (sender_ok()) begin
        pending = 1;
        ma = 1;
      end
    end
  endtask

  task automatic predict_result(req_t r, output resp_t e);
    e = '{default: '0};
    case (r.op)
      mrlp_pkg::OP_RX: begin
        if (r.rx == mrlp_pkg::CH_CR) begin
        end else if (r.rx == mrlp_pkg::CH_PROMPT && line_len == 0) begin
          line_mem[0] = mrlp_pkg::CH_PROMPT;
          line_len = 1;
          e.lc = 1;
          e.pr = 1;
        end else if (r.rx != mrlp_pkg::CH_LF) begin
          if (line_len < LINE_D - 1) begin
            line_mem[line_len] = r.rx;
            line_len++;
          end else line_len = 0;
        end else if (line_len != 0) begin
          finish_line(e.sc, e.hu, e.ma);
          e.lc = 1;
          line_len = 0;
        end
      end
      mrlp_pkg::OP_BODY:   e.rd = (r.idx < BODY_D) ? body_mem[r.idx] : mrlp_pkg::CH_NUL;
      mrlp_pkg::OP_SENDER: e.rd = (r.idx < SENDER_D) ? sender_mem[r.idx] : mrlp_pkg::CH_NUL;
      default:   pending = 0;
    endcase
    e.av = pending;
  endtask

  always @(posedge clk) begin
    resp_t e;
    req_t r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) report("unexpected result", 0, 1);
        else begin
          e = expected_q.pop_front();
          if (line_complete !== e.lc) report("line_complete", e.lc, line_complete);
          if (prompt_seen !== e.pr) report("prompt_seen", e.pr, prompt_seen);
          if (send_confirmed !== e.sc) report("send_confirmed", e.sc, send_confirmed);
          if (message_accepted !== e.ma) report("message_accepted", e.ma, message_accepted);
          if (hang_up_request !== e.hu) report("hang_up_request", e.hu, hang_up_request);
          if (message_available !== e.av) report("message_available", e.av, message_available);
          if (read_data !== e.rd) report("read_data", e.rd, read_data);
        end
      end
      if (in_valid && in_ready) begin
        r = '{op, rx_byte, read_index};
        predict_result(r, e);
        expected_q.push_back(e);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mrlp_pkg::REG_AUTH_LOW:  auth_lo = cfg_data;
          mrlp_pkg::REG_AUTH_MID:  auth_mid = cfg_data;
          mrlp_pkg::REG_AUTH_HIGH: auth_hi = cfg_data[23:0];
          default:                 auth_len = cfg_data[4:0];
        endcase
      end
    end
    req_taken <= in_valid && in_ready;
  end

  always @(negedge clk) begin
    if (rst) in_valid <= 0;
    else if (!in_valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 0;
      end else if (request_q.size() > 0) begin
        drv_req = request_q.pop_front();
        op <= drv_req.op;
        rx_byte <= drv_req.rx;
        read_index <= drv_req.idx;
        in_valid <= 1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else in_valid <= 0;
    end
  end

  always @(negedge clk) begin
    stall_cnt++;
    if (stall_cnt >= 300) begin
      stall_cnt = 0;
      stall_on = $urandom_range(0, 2) != 0;
    end
    out_ready <= rst ? 1'b0 : (!stall_on || $urandom_range(0, 3) == 0);
  end

  task automatic put_req(logic [1:0] o, logic [7:0] b, logic [7:0] i);
    request_q.push_back('{o, b, i});
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_req(mrlp_pkg::OP_RX, s[i], $urandom());
  endtask

  task automatic put_bytes(byte_q_t q);
    foreach (q[i]) put_req(mrlp_pkg::OP_RX, q[i], $urandom());
  endtask

  task automatic put_eol();
    if ($urandom_range(0, 2) != 0) put_req(mrlp_pkg::OP_RX, mrlp_pkg::CH_CR, $urandom());
    put_req(mrlp_pkg::OP_RX, mrlp_pkg::CH_LF, $urandom());
  endtask

  function automatic byte_q_t rand_text(int n, bit no_quote);
    byte_q_t q;
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(8'h20, 8'h7e);
      if (no_quote && c == mrlp_pkg::CH_QUOTE) c = "#";
      if (!no_quote && $urandom_range(0, 60) == 0) c = mrlp_pkg::CH_NUL;
      q.push_back(c);
    end
    return q;
  endfunction

  function automatic byte_q_t allowed_text();
    byte_q_t q;
    for (int i = 0; i < allowed_count(); i++) q.push_back(allowed_char(i));
    return q;
  endfunction

  task automatic settle();
    while (request_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic configure(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi,
                           logic [63:0] len);
    settle();
    write_reg(mrlp_pkg::REG_AUTH_LOW, lo);
    write_reg(mrlp_pkg::REG_AUTH_MID, mid);
    write_reg(mrlp_pkg::REG_AUTH_HIGH, hi);
    write_reg(mrlp_pkg::REG_AUTH_LEN, len);
  endtask

  task automatic random_traffic(int count, bit with_overflow);
    int sel, n;
    byte_q_t q;
    if (with_overflow) begin
      repeat (300) put_req(mrlp_pkg::OP_RX, "A", 0);
      put_eol();
    end
    while (request_q.size() < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        put_text("+CMT: \"");
        if ($urandom_range(0, 1)) q = allowed_text();
        else q = rand_text($urandom_range(0, 25), 1);
        put_bytes(q);
        if ($urandom_range(0, 9) == 0) put_text(",no quote end");
        else put_text("\",\"\",\"24/01/01\"");
        put_eol();
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(190, 230) : $urandom_range(0, 30);
        put_bytes(rand_text(n, 0));
        put_eol();
        repeat ($urandom_range(0, 3))
          put_req(mrlp_pkg::OP_BODY, $urandom(), $urandom_range(0, 35));
        repeat ($urandom_range(0, 2))
          put_req(mrlp_pkg::OP_SENDER, $urandom(), $urandom_range(0, 21));
        if ($urandom_range(0, 1)) put_req(mrlp_pkg::OP_REL, $urandom(), $urandom());
      end else if (sel < 35) begin
        put_text("+CMGS: 42");
        put_eol();
        if ($urandom_range(0, 4) == 0) begin
          put_text("ERROR");
          put_eol();
        end
        put_text("OK");
        put_eol();
      end else if (sel < 42) begin
        put_text("RING");
        put_eol();
      end else if (sel < 48) begin
        put_text("ERROR");
        put_eol();
      end else if (sel < 55) begin
        put_req(mrlp_pkg::OP_RX, mrlp_pkg::CH_PROMPT, $urandom());
        put_bytes(rand_text($urandom_range(0, 8), 0));
        put_eol();
      end else if (sel < 70) begin
        repeat ($urandom_range(1, 4))
          put_req($urandom_range(mrlp_pkg::OP_BODY, mrlp_pkg::OP_REL), $urandom(),
                  $urandom_range(0, 1) ? $urandom_range(0, 25) : $urandom_range(0, 255));
      end else if (sel < 90) begin
        put_bytes(rand_text($urandom_range(0, 20), 0));
        put_eol();
      end else begin
        repeat ($urandom_range(1, 6))
          put_req(mrlp_pkg::OP_RX, $urandom_range(0, 255), $urandom());
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    configure("+1555123", "4567", 0, 12);
    put_req(mrlp_pkg::OP_RX, mrlp_pkg::CH_CR, 0);
    put_req(mrlp_pkg::OP_RX, mrlp_pkg::CH_LF, 0);
    put_req(mrlp_pkg::OP_RX, mrlp_pkg::CH_PROMPT, 0);
    put_req(mrlp_pkg::OP_RX, mrlp_pkg::CH_LF, 0);
    put_req(mrlp_pkg::OP_BODY, 0, 8'hff);
    put_req(mrlp_pkg::OP_SENDER, 0, 0);
    put_req(mrlp_pkg::OP_SENDER, 0, 8'd19);
    put_req(mrlp_pkg::OP_REL, 0, 0);
    put_text("RING\n+CMGS:\nOK\nOK\n");
    random_traffic(380, 0);

    configure("ABCDEFGH", "IJKLMNOP", "QRS", 19);
    random_traffic(380, 1);
    configure('1, '1, '1, '1);
    random_traffic(360, 0);
    configure({$urandom(), $urandom()}, {$urandom(), $urandom()}, $urandom(), 0);
    random_traffic(340, 0);
    configure("12345\0009", "", "", 10);
    random_traffic(340, 0);

    settle();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

@@ modem_response_line_parser.f @@
sv/mrlp_pkg.sv
sv/modem_response_line_parser.sv
dv/modem_response_line_parser_tb.sv
